// ===== sv/rotary_detent_decoder_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ROTARY_DETENT_DECODER_MACROS_SVH
`define ROTARY_DETENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RDD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define RDD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rdd_pkg.sv =====
`default_nettype none

package rdd_pkg;

   // Field widths
   localparam int unsigned PosWidth  = 16;
   localparam int unsigned StepWidth = 15;
   localparam int unsigned AddrWidth = 4;
   localparam int unsigned DataWidth = 32;
   // Position plus or minus step, with room for the range check
   localparam int unsigned SumWidth  = PosWidth + 2;

   // Register map, index = byte address / 4
   typedef enum logic [1:0] {
      REG_VALUE_MIN = 2'd0,
      REG_VALUE_MAX = 2'd1,
      REG_STEP_SIZE = 2'd2
   } reg_index_type;

   // Values of the moved field
   typedef enum logic [1:0] {
      MOVED_NONE = 2'd0,
      MOVED_DOWN = 2'd1,
      MOVED_UP   = 2'd2
   } moved_type;

   // Register reset values
   localparam logic signed [PosWidth-1:0] ValueMinReset = 16'sd0;
   localparam logic signed [PosWidth-1:0] ValueMaxReset = 16'sd100;
   localparam logic [StepWidth-1:0]       StepSizeReset = 15'd1;

endpackage

`default_nettype wire

// ===== sv/rotary_detent_decoder.sv =====
// Pipeline: an accepted edge event passes through the input register, then the result
// register, before its result appears on rsp_valid. Throughput: one edge event per cycle
// while rsp_stall does not hold the result stage; position and arm bits update in the
// result stage, so each event sees the state left by the one before it.
// Reset (synchronous, active high): arm bits and position clear to zero, value_min = 0,
// value_max = 100, step_size = 1; both pipeline stages empty.
`default_nettype none

module rotary_detent_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // edge event channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_edge_on_b,
   input  wire logic                                req_level_a,
   input  wire logic                                req_level_b,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [rdd_pkg::PosWidth-1:0]      rsp_position,
   output logic [1:0]                               rsp_moved,
   // register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rdd_pkg::AddrWidth-1:0]       csr_paddr,
   input  wire logic [rdd_pkg::DataWidth-1:0]       csr_pwdata,
   output logic [rdd_pkg::DataWidth-1:0]            csr_prdata,
   output logic                                     csr_pready
);

   localparam int unsigned PW = rdd_pkg::PosWidth;
   localparam int unsigned SW = rdd_pkg::StepWidth;
   localparam int unsigned XW = rdd_pkg::SumWidth;

   // configuration registers
   logic signed [PW-1:0] value_min_ff;
   logic signed [PW-1:0] value_max_ff;
   logic [SW-1:0]        step_size_ff;

   // input stage
   logic in_valid_ff;
   logic in_edge_on_b_ff;
   logic in_level_a_ff;
   logic in_level_b_ff;

   // decoder state
   logic                 expect_a_ff, expect_a_in;
   logic                 expect_b_ff, expect_b_in;
   logic signed [PW-1:0] position_ff, position_in;

   // result stage
   logic                 rsp_valid_ff;
   logic signed [PW-1:0] rsp_position_ff;
   rdd_pkg::moved_type   rsp_moved_ff, moved_in;

   logic                 advance;
   logic                 csr_write;
   rdd_pkg::reg_index_type csr_index;
   logic signed [XW-1:0] pos_ext, min_ext, max_ext, step_ext;
   logic signed [XW-1:0] sum_down, sum_up;
   logic                 down_out, up_out;

   // result stage moves when it is empty or its transfer completes
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   // register port decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = rdd_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         value_min_ff <= rdd_pkg::ValueMinReset;
         value_max_ff <= rdd_pkg::ValueMaxReset;
         step_size_ff <= rdd_pkg::StepSizeReset;
      end else if (csr_write) begin
         case (csr_index)
            rdd_pkg::REG_VALUE_MIN: value_min_ff <= csr_pwdata[PW-1:0];
            rdd_pkg::REG_VALUE_MAX: value_max_ff <= csr_pwdata[PW-1:0];
            rdd_pkg::REG_STEP_SIZE: step_size_ff <= csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // register readback, signed registers sign extended
   always_comb begin
      case (csr_index)
         rdd_pkg::REG_VALUE_MIN:
            csr_prdata = {{(rdd_pkg::DataWidth-PW){value_min_ff[PW-1]}}, value_min_ff};
         rdd_pkg::REG_VALUE_MAX:
            csr_prdata = {{(rdd_pkg::DataWidth-PW){value_max_ff[PW-1]}}, value_max_ff};
         rdd_pkg::REG_STEP_SIZE:
            csr_prdata = {{(rdd_pkg::DataWidth-SW){1'b0}}, step_size_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_edge_on_b_ff <= req_edge_on_b;
         in_level_a_ff   <= req_level_a;
         in_level_b_ff   <= req_level_b;
      end
   end

   // wide intermediate for the range check
   assign pos_ext  = XW'(position_ff);
   assign min_ext  = XW'(value_min_ff);
   assign max_ext  = XW'(value_max_ff);
   assign step_ext = $signed({{(XW-SW){1'b0}}, step_size_ff});
   assign sum_down = pos_ext - step_ext;
   assign sum_up   = pos_ext + step_ext;
   assign down_out = (sum_down < min_ext) || (sum_down > max_ext);
   assign up_out   = (sum_up < min_ext) || (sum_up > max_ext);

   // detent decode
   always_comb begin
      expect_a_in = expect_a_ff;
      expect_b_in = expect_b_ff;
      position_in = position_ff;
      moved_in    = rdd_pkg::MOVED_NONE;
      if (!in_edge_on_b_ff) begin
         if (in_level_a_ff && in_level_b_ff && expect_a_ff) begin
            // A edge back into detent: step down, wrap to max
            position_in = down_out ? value_max_ff : sum_down[PW-1:0];
            expect_a_in = 1'b0;
            expect_b_in = 1'b0;
            moved_in    = rdd_pkg::MOVED_DOWN;
         end else if (in_level_a_ff && !in_level_b_ff) begin
            expect_a_in = 1'b0;
            expect_b_in = 1'b1;
         end
      end else begin
         if (in_level_a_ff && in_level_b_ff && expect_b_ff) begin
            // B edge back into detent: step up, wrap to min
            position_in = up_out ? value_min_ff : sum_up[PW-1:0];
            expect_a_in = 1'b0;
            expect_b_in = 1'b0;
            moved_in    = rdd_pkg::MOVED_UP;
         end else if (in_level_b_ff && !in_level_a_ff) begin
            expect_a_in = 1'b1;
            expect_b_in = 1'b0;
         end
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_a_ff  <= 1'b0;
         expect_b_ff  <= 1'b0;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            expect_a_ff <= expect_a_in;
            expect_b_ff <= expect_b_in;
            position_ff <= position_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_position_ff <= position_in;
         rsp_moved_ff    <= moved_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_moved    = rsp_moved_ff;

endmodule

`default_nettype wire

// ===== sv/rotary_detent_decoder_checker.sv =====
`default_nettype none

`include "rotary_detent_decoder_macros.svh"

module rotary_detent_decoder_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [rdd_pkg::PosWidth-1:0] rsp_position,
   input wire logic [1:0]                          rsp_moved,
   input wire logic                                csr_psel,
   input wire logic                                csr_pready
);

   logic                                rsp_xfer;
   logic signed [rdd_pkg::PosWidth-1:0] last_pos_ff;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   // position last delivered, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= '0;
      end else if (rsp_xfer) begin
         last_pos_ff <= rsp_position;
      end
   end

   // reset empties the result stage
   `RDD_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid,
      "result valid after reset")

   // moved carries one of its three codes
   `RDD_ASSERT_NOW(a_moved_code, clock, reset, rsp_valid,
      rsp_moved == rdd_pkg::MOVED_NONE || rsp_moved == rdd_pkg::MOVED_DOWN ||
      rsp_moved == rdd_pkg::MOVED_UP, "moved holds an unused code")

   // an event without a move leaves the position as last delivered
   `RDD_ASSERT_NOW(a_hold_position, clock, reset,
      rsp_xfer && rsp_moved == rdd_pkg::MOVED_NONE, rsp_position == last_pos_ff,
      "position changed without a move")

   // a stalled result holds
   `RDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_position) && $stable(rsp_moved),
      "stalled result changed")

   // the register port never waits
   `RDD_ASSERT_NOW(a_pready, clock, reset, csr_psel, csr_pready,
      "register port not ready")

endmodule

bind rotary_detent_decoder rotary_detent_decoder_checker u_checker (.*);

`default_nettype wire

// ===== bench/detent_monitor.sv =====
`timescale 1ns / 100ps

module detent_monitor
   import rdd_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   // edge event channel
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic                        req_edge_on_b,
   input  wire logic                        req_level_a,
   input  wire logic                        req_level_b,
   // result channel
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic signed [PosWidth-1:0]  rsp_position,
   input  wire logic [1:0]                  rsp_moved,
   // register port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [AddrWidth-1:0]        csr_paddr,
   input  wire logic [DataWidth-1:0]        csr_pwdata,
   input  wire logic                        csr_pready,
   output int                               fail_count,
   output int                               results_owed
);

   typedef struct {
      logic signed [PosWidth-1:0] position;
      moved_type                  moved;
   } detent_result_t;

   // Shadow copy of the register file
   logic signed [PosWidth-1:0] lo_limit;
   logic signed [PosWidth-1:0] hi_limit;
   logic [StepWidth-1:0]       step_amt;

   // Shadow copy of the decoder state
   logic                       arm_a;
   logic                       arm_b;
   logic signed [PosWidth-1:0] position_now;

   // Positions not yet seen on the result channel, oldest first
   detent_result_t owed_positions[$];
   int             rsp_count;

   initial begin
      fail_count   = 0;
      results_owed = 0;
      rsp_count    = 0;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      // keep the log readable if the design is badly broken
      if (fail_count <= 200) begin
         $display("%0t ns: ERROR: %s", $time, msg);
      end
   endtask

   // Apply one edge event to the shadow state and return the result it gives
   function automatic detent_result_t decode_edge(input logic on_b, input logic a,
                                                  input logic b);
      detent_result_t res;
      int             sum;
      res.moved = MOVED_NONE;
      if (!on_b) begin
         if (a && b && arm_a) begin
            sum = int'(position_now) - int'(step_amt);
            if (sum < int'(lo_limit) || sum > int'(hi_limit)) begin
               sum = int'(hi_limit);
            end
            position_now = sum[PosWidth-1:0];
            arm_a        = 1'b0;
            arm_b        = 1'b0;
            res.moved    = MOVED_DOWN;
         end else if (a && !b) begin
            arm_b = 1'b1;
            arm_a = 1'b0;
         end
      end else begin
         if (a && b && arm_b) begin
            sum = int'(position_now) + int'(step_amt);
            if (sum < int'(lo_limit) || sum > int'(hi_limit)) begin
               sum = int'(lo_limit);
            end
            position_now = sum[PosWidth-1:0];
            arm_a        = 1'b0;
            arm_b        = 1'b0;
            res.moved    = MOVED_UP;
         end else if (b && !a) begin
            arm_a = 1'b1;
            arm_b = 1'b0;
         end
      end
      res.position = position_now;
      return res;
   endfunction

   always @(posedge clock) begin
      detent_result_t want;
      if (reset) begin
         lo_limit     = ValueMinReset;
         hi_limit     = ValueMaxReset;
         step_amt     = StepSizeReset;
         arm_a        = 1'b0;
         arm_b        = 1'b0;
         position_now = '0;
         owed_positions.delete();
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_VALUE_MIN: lo_limit = csr_pwdata[PosWidth-1:0];
               REG_VALUE_MAX: hi_limit = csr_pwdata[PosWidth-1:0];
               REG_STEP_SIZE: step_amt = csr_pwdata[StepWidth-1:0];
               default: ;
            endcase
         end

         // compare each result transfer with the oldest expected position
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (owed_positions.size() == 0) begin
               report_mismatch($sformatf("result %0d with no event outstanding", rsp_count));
            end else begin
               want = owed_positions.pop_front();
               if (rsp_position !== want.position || rsp_moved !== want.moved) begin
                  report_mismatch($sformatf(
                     "result %0d: position %0d moved %0d, expected position %0d moved %0d",
                     rsp_count, rsp_position, rsp_moved, want.position, want.moved));
               end
            end
         end

         // predict each accepted edge event
         if (req_valid && !req_stall) begin
            owed_positions.push_back(decode_edge(req_edge_on_b, req_level_a, req_level_b));
         end
      end
      results_owed <= owed_positions.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import rdd_pkg::*;

   localparam logic PinA          = 1'b0;
   localparam logic PinB          = 1'b1;
   localparam int   RandomPhases  = 8;
   localparam int   PhaseEvents   = 90;
   localparam int   WatchdogLimit = 4000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_edge_on_b;
   logic                       req_level_a;
   logic                       req_level_b;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [PosWidth-1:0] rsp_position;
   logic [1:0]                 rsp_moved;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [AddrWidth-1:0]       csr_paddr;
   logic [DataWidth-1:0]       csr_pwdata;
   logic [DataWidth-1:0]       csr_prdata;
   logic                       csr_pready;

   int fail_count;
   int results_owed;
   int idle_pct;
   int stall_pct;
   int events_sent;
   int quiet_cycles;

   rotary_detent_decoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_edge_on_b (req_edge_on_b),
      .req_level_a   (req_level_a),
      .req_level_b   (req_level_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_position  (rsp_position),
      .rsp_moved     (rsp_moved),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   detent_monitor i_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_edge_on_b (req_edge_on_b),
      .req_level_a   (req_level_a),
      .req_level_b   (req_level_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_position  (rsp_position),
      .rsp_moved     (rsp_moved),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .results_owed  (results_owed)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // random backpressure on the result channel
   always @(posedge clock) begin
      rsp_stall <= (int'($urandom_range(0, 99)) < stall_pct);
   end

   // watchdog: too many cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one edge event transfer, with random idle cycles ahead of it
   task automatic send_event(input logic on_b, input logic a, input logic b);
      while (int'($urandom_range(0, 99)) < idle_pct) begin
         req_valid     <= 1'b0;
         req_edge_on_b <= 1'($urandom_range(0, 1));
         req_level_a   <= 1'($urandom_range(0, 1));
         req_level_b   <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_edge_on_b <= on_b;
      req_level_a   <= a;
      req_level_b   <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      events_sent++;
   endtask

   // hold off new events until every result has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // setup cycle, access cycle, then the bus returns to idle
   task automatic write_reg(input reg_index_type idx, input logic [DataWidth-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input logic signed [PosWidth-1:0] lo,
                               input logic signed [PosWidth-1:0] hi,
                               input logic [StepWidth-1:0] stp);
      wait_idle();
      write_reg(REG_VALUE_MIN, {16'h0000, lo});
      write_reg(REG_VALUE_MAX, {16'h0000, hi});
      write_reg(REG_STEP_SIZE, {17'h00000, stp});
   endtask

   task automatic random_config();
      int lo;
      int hi;
      int stp;
      int pick;
      case ($urandom_range(0, 3))
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            lo = int'($urandom_range(0, 400)) - 200;
            hi = lo + int'($urandom_range(0, 30));
         end
         2: begin
            lo = int'($urandom_range(0, 65535)) - 32768;
            hi = int'($urandom_range(0, 65535)) - 32768;
         end
         default: begin
            // inverted range
            hi = int'($urandom_range(0, 60)) - 30;
            lo = hi + int'($urandom_range(1, 20));
         end
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 6) stp = $urandom_range(0, 9);
      else if (pick < 8) stp = $urandom_range(0, 32767);
      else if (pick == 8) stp = 32767;
      else stp = 0;
      write_config(lo[PosWidth-1:0], hi[PosWidth-1:0], stp[StepWidth-1:0]);
   endtask

   // mostly full detents in a random direction, some noise, half detents and lone closing edges
   task automatic random_motion();
      int   pick;
      logic clockwise;
      pick      = $urandom_range(0, 99);
      clockwise = 1'($urandom_range(0, 1));
      if (pick < 70) begin
         if (clockwise) begin
            send_event(PinA, 1'b1, 1'b0);
            send_event(PinB, 1'b1, 1'b1);
         end else begin
            send_event(PinB, 1'b0, 1'b1);
            send_event(PinA, 1'b1, 1'b1);
         end
      end else if (pick < 85) begin
         send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
         if (clockwise) send_event(PinA, 1'b1, 1'b0);
         else send_event(PinB, 1'b0, 1'b1);
      end else begin
         // closing edge without its opener
         if (clockwise) send_event(PinB, 1'b1, 1'b1);
         else send_event(PinA, 1'b1, 1'b1);
      end
   endtask

   initial begin
      int idle_modes[4];
      int stall_modes[4];
      int target;
      idle_modes  = '{0, 67, 0, 7};
      stall_modes = '{0, 0, 67, 7};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_edge_on_b = 1'b0;
      req_level_a   = 1'b0;
      req_level_b   = 1'b0;
      rsp_stall     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      idle_pct      = 0;
      stall_pct     = 0;
      events_sent   = 0;
      quiet_cycles  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pin combinations that move nothing with no arm set
      send_event(PinA, 1'b0, 1'b0);
      send_event(PinA, 1'b0, 1'b1);
      send_event(PinA, 1'b1, 1'b1);
      send_event(PinB, 1'b1, 1'b1);
      send_event(PinB, 1'b0, 1'b0);
      send_event(PinB, 1'b1, 1'b0);
      // decrement from zero falls below the minimum, wraps to the maximum
      send_event(PinB, 1'b0, 1'b1);
      send_event(PinA, 1'b1, 1'b1);
      // increment past the maximum wraps to the minimum
      send_event(PinA, 1'b1, 1'b0);
      send_event(PinB, 1'b1, 1'b1);
      // arming the other pin drops the first arm
      send_event(PinA, 1'b1, 1'b0);
      send_event(PinB, 1'b0, 1'b1);
      send_event(PinB, 1'b1, 1'b1);
      send_event(PinA, 1'b1, 1'b1);

      // full range, largest step: overflow and underflow of the 16-bit span
      write_config(-16'sd32768, 16'sd32767, 15'd32767);
      send_event(PinA, 1'b1, 1'b0);
      send_event(PinB, 1'b1, 1'b1);
      send_event(PinB, 1'b0, 1'b1);
      send_event(PinA, 1'b1, 1'b1);
      send_event(PinB, 1'b0, 1'b1);
      send_event(PinA, 1'b1, 1'b1);

      // inverted range with zero step: every move wraps
      write_config(16'sd100, -16'sd100, 15'd0);
      send_event(PinB, 1'b0, 1'b1);
      send_event(PinA, 1'b1, 1'b1);
      send_event(PinA, 1'b1, 1'b0);
      send_event(PinB, 1'b1, 1'b1);

      // position left outside a narrow range until the next move
      write_config(-16'sd5, 16'sd5, 15'd0);
      send_event(PinA, 1'b1, 1'b0);
      send_event(PinB, 1'b1, 1'b1);

      // random phases, each with its own settings and idle pattern
      for (int phase = 0; phase < RandomPhases; phase++) begin
         random_config();
         idle_pct  = idle_modes[phase % 4];
         stall_pct = stall_modes[phase % 4];
         target    = events_sent + PhaseEvents;
         while (events_sent < target) random_motion();
      end

      wait_idle();
      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
